// ===== rtl/core/fpic_pkg.sv =====
// Shared types and constants for the frame pacing interval controller.
package fpic_pkg;

  localparam int TIME_W = 24;
  localparam int FPS_W = 10;
  localparam int OP_W = 2;
  localparam int BUSY_W = 3;
  localparam int DIV_W = 10;
  localparam int SCALE_W = 20;

  localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_RELOAD = 2'd2;

  localparam logic [FPS_W-1:0] RESET_FPS = 10'd15;
  localparam logic [TIME_W-1:0] RESET_PERIOD = 24'd66000;
  localparam logic [DIV_W-1:0] FPS_SCALE = 10'd1000;
  localparam logic [BUSY_W-1:0] MAX_BUSY = 3'd3;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [TIME_W-1:0] frame_time_us;
  } fpic_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] interval_us;
    logic [TIME_W-1:0] average_us;
    logic fire;
    logic [BUSY_W-1:0] pending_count;
  } fpic_out_t;

endpackage

// ===== rtl/core/frame_pacing_interval_controller.sv =====
// Frame pacer top level: duration window, fps divider and sequencer.
// A frame done transaction passes through the read, average and done states; a tick or an unused op
// goes straight to done; a reload runs the 10-step restoring divide of 1000 by the fps setting, then scale and fill.
// One transaction is worked on at a time; input stall is high until the result is registered,
// which also waits while an earlier result is still stalled at the output.
// Synchronous reset sets the state of a reload at 15 fps; the window is marked empty at once
// and empty entries read as the ideal period, so no clearing pass is needed.
module frame_pacing_interval_controller #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fpic_pkg::FPS_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fpic_pkg::fpic_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fpic_pkg::fpic_out_t           out_data
);
  import fpic_pkg::*;

  function automatic int low_zeros(input int value);
    int count;
    int rest;
    count = 0;
    rest = value;
    while ((rest & 1) == 0) begin
      rest = rest >> 1;
      count++;
    end
    return count;
  endfunction

  function automatic longint unsigned reciprocal(input int k, input int d);
    longint unsigned scaled;
    scaled = 64'd1 << k;
    return (scaled + 64'(d) - 64'd1) / 64'(d);
  endfunction

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = TIME_W + IDX_W;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int AVG_SHIFT = low_zeros(WINDOW_DEPTH);
  localparam int AVG_ODD = WINDOW_DEPTH >> AVG_SHIFT;
  localparam int ODD_W = $clog2(AVG_ODD);
  localparam int X_W = SUM_W - AVG_SHIFT;
  localparam int RECIP_K = X_W + ODD_W;
  localparam int RECIP_W = X_W + 1;
  localparam int PROD_W = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(reciprocal(RECIP_K, AVG_ODD));

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FPS_DIV,
    S_SCALE,
    S_FILL,
    S_AVG,
    S_DONE
  } state_t;

  state_t state;
  logic [FPS_W-1:0] required_fps;
  logic [OP_W-1:0] op;
  logic [TIME_W-1:0] frame_time;
  logic [TIME_W-1:0] window_mem [WINDOW_DEPTH];
  logic [TIME_W-1:0] rd_data;
  logic [WINDOW_DEPTH-1:0] filled;
  logic [IDX_W-1:0] head;
  logic [SUM_W-1:0] window_sum;
  logic [TIME_W-1:0] average_time;
  logic [TIME_W-1:0] ideal_period;
  logic [BUSY_W-1:0] pending;
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] div_quo;
  logic [CNT_W-1:0] div_cnt;

  logic [DIV_W:0] trial;
  logic trial_ge;
  logic [DIV_W-1:0] div_rem_next;
  logic [TIME_W-1:0] old_entry;
  logic [SUM_W-1:0] sum_next;
  logic [PROD_W-1:0] avg_prod;
  logic out_free;
  logic tick_fires;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign trial = {div_rem, div_quo[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign div_rem_next = trial_ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
  assign old_entry = filled[head] ? rd_data : ideal_period;
  assign sum_next = window_sum - SUM_W'(old_entry) + SUM_W'(frame_time);
  assign avg_prod = PROD_W'(window_sum[SUM_W-1:AVG_SHIFT]) * PROD_W'(AVG_RECIP);
  assign tick_fires = (pending <= MAX_BUSY);

  always_ff @(posedge clk) begin
    rd_data <= window_mem[head];
    if (state == S_READ) begin
      window_mem[head] <= frame_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      required_fps <= RESET_FPS;
      filled <= '0;
      head <= '0;
      window_sum <= SUM_W'(RESET_PERIOD) * SUM_W'(WINDOW_DEPTH);
      average_time <= RESET_PERIOD;
      ideal_period <= RESET_PERIOD;
      pending <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        required_fps <= cfg_wr_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= in_data.op;
            frame_time <= in_data.frame_time_us;
            if (in_data.op == OP_FRAME) begin
              state <= S_READ;
            end else if (in_data.op == OP_RELOAD) begin
              div_rem <= '0;
              div_quo <= FPS_SCALE;
              divisor <= (required_fps == '0) ? DIV_W'(1) : DIV_W'(required_fps);
              div_cnt <= CNT_W'(DIV_W - 1);
              state <= S_FPS_DIV;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          window_sum <= sum_next;
          filled[head] <= 1'b1;
          head <= (head == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
          if (pending != '0) begin
            pending <= pending - 1'b1;
          end
          state <= S_AVG;
        end
        S_AVG: begin
          average_time <= avg_prod[RECIP_K +: TIME_W];
          state <= S_DONE;
        end
        S_FPS_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= {div_quo[DIV_W-2:0], trial_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          ideal_period <= TIME_W'(SCALE_W'(div_quo) * SCALE_W'(FPS_SCALE));
          filled <= '0;
          state <= S_FILL;
        end
        S_FILL: begin
          window_sum <= SUM_W'(ideal_period) * SUM_W'(WINDOW_DEPTH);
          average_time <= ideal_period;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data.average_us <= average_time;
            if (op == OP_TICK) begin
              out_data.interval_us <= (average_time > ideal_period) ?
                                      (average_time >> 1) : ideal_period;
              out_data.fire <= tick_fires;
              out_data.pending_count <= tick_fires ? pending + 1'b1 : pending;
              if (tick_fires) begin
                pending <= pending + 1'b1;
              end
            end else begin
              out_data.interval_us <= '0;
              out_data.fire <= 1'b0;
              out_data.pending_count <= pending;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
